[design/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants for the sticky backoff station
// Holds field widths, the slot operation codes and the request record.
// ----------------------------------------------------------------------------
package sbs_pkg;

   localparam int unsigned COUNT_W     = 9;
   localparam int unsigned CREDIT_W    = 8;
   localparam int unsigned TOTAL_W     = 32;
   localparam int unsigned STAGE_OUT_W = 3;

   // quotient by reciprocal: exact for any 9-bit dividend and divisor below 512
   localparam int unsigned RECIP_SHIFT = 18;
   localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic {
      OP_START = 1'b0,
      OP_SLOT  = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               others_transmitted;
      logic [COUNT_W-1:0] random_bits;
   } slot_req_type;

endpackage

[design/sticky_backoff_station.sv]
// ----------------------------------------------------------------------------
// sticky_backoff_station: slotted exponential backoff engine with sticky backoff
// Input register, then result register; 1 transaction per cycle while the output drains.
// The slot update is one pass of compare, multiply and subtract logic between them.
// Synchronous active-high reset clears valid flags and station state, not payload; the stickiness limit resets to 0.
// ----------------------------------------------------------------------------
module sticky_backoff_station
   import sbs_pkg::*;
#(
   parameter int unsigned MIN_WINDOW = 16,
   parameter int unsigned TOP_STAGE  = 5
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic                   req_others_transmitted,
   input  logic [COUNT_W-1:0]     req_random_bits,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_transmitted,
   output logic                   rsp_succeeded,
   output logic                   rsp_collided,
   output logic [COUNT_W-1:0]     rsp_backoff_now,
   output logic [STAGE_OUT_W-1:0] rsp_stage_now,
   output logic [CREDIT_W-1:0]    rsp_sticky_left,
   output logic [TOTAL_W-1:0]     rsp_success_total,
   output logic [TOTAL_W-1:0]     rsp_collision_total,

   input  logic                   csr_wr_en,
   input  logic [CREDIT_W-1:0]    csr_wr_data
);

   localparam int unsigned NUM_STAGES = TOP_STAGE + 1;
   localparam int unsigned STAGE_W    = $clog2(TOP_STAGE + 1);
   localparam int unsigned PROD_W     = COUNT_W + RECIP_SHIFT;

   // Per-stage constants: window size, deterministic backoff and the
   // reciprocal of the window used to split random_bits into window units.
   logic [COUNT_W-1:0] win_tab   [NUM_STAGES];
   logic [COUNT_W-1:0] fix_tab   [NUM_STAGES];
   logic [RECIP_W-1:0] recip_tab [NUM_STAGES];
   logic [COUNT_W-1:0] quot_in   [NUM_STAGES];
   logic [COUNT_W-1:0] quot_ff   [NUM_STAGES];

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      localparam longint unsigned WIN   = longint'(MIN_WINDOW) << s;
      localparam longint unsigned FIX   = (longint'(MIN_WINDOW) / 2) << s;
      localparam longint unsigned RECIP = (WIN > longint'(COUNT_MAX)) ? 0 :
                                          ((64'd1 << RECIP_SHIFT) + WIN - 1) / WIN;
      logic [PROD_W-1:0] prod;

      assign win_tab[s]   = COUNT_W'(WIN);
      assign fix_tab[s]   = (FIX > longint'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(FIX);
      assign recip_tab[s] = RECIP_W'(RECIP);

      // Quotient of random_bits by this stage's window; zero when the window
      // covers every 9-bit value, so the draw is the bits themselves.
      assign prod       = PROD_W'(req_random_bits) * PROD_W'(recip_tab[s]);
      assign quot_in[s] = prod[RECIP_SHIFT +: COUNT_W];
   end

   // ------------------------------------------------------------------
   // Handshake: input register feeds the result register; both advance
   // together so a new transaction enters every cycle the output drains.
   // ------------------------------------------------------------------
   logic         s1_valid_ff;
   slot_req_type s1_req_ff;
   logic         rsp_valid_ff;
   logic         advance;
   logic         take;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take      = req_valid && req_ready;

   // Station state and the configuration register
   logic [CREDIT_W-1:0] max_sticky_ff;
   logic [COUNT_W-1:0]  count_ff,   count_in;
   logic [STAGE_W-1:0]  stage_ff,   stage_in;
   logic [CREDIT_W-1:0] credits_ff, credits_in;
   logic [TOTAL_W-1:0]  succ_ff,    succ_in;
   logic [TOTAL_W-1:0]  colls_ff,   colls_in;

   // Slot update
   logic                 tx_in, ok_in, coll_in;
   logic [STAGE_W-1:0]   stage_up;
   logic [STAGE_W-1:0]   draw_stage;
   logic [COUNT_W-1:0]   draw_quot;
   logic [2*COUNT_W-1:0] draw_prod;
   logic [COUNT_W-1:0]   rand_draw;
   logic [COUNT_W-1:0]   fix_draw;
   logic [COUNT_W-1:0]   count_upd;
   logic [TOTAL_W-1:0]   weight;
   logic [TOTAL_W:0]     succ_sum;
   logic [STAGE_W+STAGE_OUT_W-1:0] stage_ext;

   assign stage_up = (stage_ff < STAGE_W'(TOP_STAGE)) ? stage_ff + 1'b1 : stage_ff;
   assign weight   = TOTAL_W'(1) << stage_ff;
   assign succ_sum = {1'b0, succ_ff} + {1'b0, weight};
   assign fix_draw = fix_tab[stage_ff];

   // Pick the stage whose window the draw uses: zero on start, the raised
   // stage when others transmitted and no credits are left, the current stage otherwise.
   always_comb begin
      if (s1_req_ff.op == OP_START) begin
         draw_stage = '0;
      end else if (s1_req_ff.others_transmitted && credits_ff == '0) begin
         draw_stage = stage_up;
      end else begin
         draw_stage = stage_ff;
      end
   end

   // Remainder = bits - quotient * window
   assign draw_quot = quot_ff[draw_stage];
   assign draw_prod = {{COUNT_W{1'b0}}, draw_quot} * {{COUNT_W{1'b0}}, win_tab[draw_stage]};
   assign rand_draw = s1_req_ff.random_bits - draw_prod[COUNT_W-1:0];

   always_comb begin
      tx_in      = 1'b0;
      ok_in      = 1'b0;
      coll_in    = 1'b0;
      stage_in   = stage_ff;
      credits_in = credits_ff;
      succ_in    = succ_ff;
      colls_in   = colls_ff;
      count_upd  = count_ff;
      count_in   = count_ff;
      case (s1_req_ff.op)
         OP_START: begin
            // Clear the station and draw from the minimum window
            stage_in   = '0;
            credits_in = '0;
            succ_in    = '0;
            colls_in   = '0;
            count_in   = rand_draw;
         end
         default: begin
            if (count_ff == '0) begin
               tx_in = 1'b1;
               if (!s1_req_ff.others_transmitted) begin
                  // Lone transmission: weight the success by the stage
                  ok_in   = 1'b1;
                  succ_in = succ_sum[TOTAL_W] ? '1 : succ_sum[TOTAL_W-1:0];
                  if (max_sticky_ff != '0) begin
                     count_upd = fix_draw;
                     if (credits_ff < max_sticky_ff) begin
                        credits_in = max_sticky_ff;
                     end
                  end else begin
                     count_upd = rand_draw;
                  end
               end else begin
                  // Collision: spend a credit, or back off to a wider window
                  coll_in  = 1'b1;
                  colls_in = (colls_ff == '1) ? colls_ff : colls_ff + 1'b1;
                  if (credits_ff != '0) begin
                     count_upd  = fix_draw;
                     credits_in = credits_ff - 1'b1;
                  end else begin
                     stage_in  = stage_up;
                     count_upd = rand_draw;
                  end
               end
            end
            // Count down one slot
            count_in = (count_upd != '0) ? count_upd - 1'b1 : count_upd;
         end
      endcase
   end

   assign stage_ext = {{STAGE_OUT_W{1'b0}}, stage_in};

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_sticky_ff <= '0;
         count_ff      <= '0;
         stage_ff      <= '0;
         credits_ff    <= '0;
         succ_ff       <= '0;
         colls_ff      <= '0;
      end else begin
         if (take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            max_sticky_ff <= csr_wr_data;
         end
         if (advance) begin
            count_ff   <= count_in;
            stage_ff   <= stage_in;
            credits_ff <= credits_in;
            succ_ff    <= succ_in;
            colls_ff   <= colls_in;
         end
      end
   end

   // Payload: hold the captured transaction and its quotient lanes
   always_ff @(posedge clock) begin
      if (take) begin
         s1_req_ff.op                 <= op_type'(req_op);
         s1_req_ff.others_transmitted <= req_others_transmitted;
         s1_req_ff.random_bits        <= req_random_bits;
         for (int s = 0; s < NUM_STAGES; s++) begin
            quot_ff[s] <= quot_in[s];
         end
      end
   end

   // Result register
   logic [COUNT_W-1:0]     rsp_backoff_ff;
   logic [STAGE_OUT_W-1:0] rsp_stage_ff;
   logic [CREDIT_W-1:0]    rsp_sticky_ff;
   logic [TOTAL_W-1:0]     rsp_succ_ff;
   logic [TOTAL_W-1:0]     rsp_colls_ff;
   logic                   rsp_tx_ff, rsp_ok_ff, rsp_coll_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tx_ff      <= tx_in;
         rsp_ok_ff      <= ok_in;
         rsp_coll_ff    <= coll_in;
         rsp_backoff_ff <= count_in;
         rsp_stage_ff   <= stage_ext[STAGE_OUT_W-1:0];
         rsp_sticky_ff  <= credits_in;
         rsp_succ_ff    <= succ_in;
         rsp_colls_ff   <= colls_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_transmitted     = rsp_tx_ff;
   assign rsp_succeeded       = rsp_ok_ff;
   assign rsp_collided        = rsp_coll_ff;
   assign rsp_backoff_now     = rsp_backoff_ff;
   assign rsp_stage_now       = rsp_stage_ff;
   assign rsp_sticky_left     = rsp_sticky_ff;
   assign rsp_success_total   = rsp_succ_ff;
   assign rsp_collision_total = rsp_colls_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef SYNTHESIS
   // Stage stays within its cap
   a_stage_cap: assert property (@(posedge clock) disable iff (reset)
      stage_ff <= STAGE_W'(TOP_STAGE))
      else $error("backoff stage above cap");

   // A transmission either succeeds or collides, never both
   a_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_transmitted == (rsp_succeeded || rsp_collided)) &&
                    !(rsp_succeeded && rsp_collided))
      else $error("inconsistent slot outcome");

   // A start transaction delivers cleared totals and no transmission
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_req_ff.op == OP_START) |=>
         (rsp_success_total == '0) && (rsp_collision_total == '0) && !rsp_transmitted)
      else $error("start did not clear the station");

   // No transmission while the counter is still running
   a_count_gate: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_req_ff.op == OP_SLOT && count_ff != '0) |=> !rsp_transmitted)
      else $error("transmitted with nonzero backoff");
`endif

endmodule
